[rtl/oil_pkg.sv]
// Package: shared types and constants for the octree insert locator.
package oil_pkg;

  // Input item: object center and bounding radius, Q16.16
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [29:0] bound_radius;
  } in_item_t;

  // Result item: where the object lands
  typedef struct packed {
    logic [20:0] node_path;
    logic [2:0]  descents;
    logic [1:0]  stop_cause;
  } out_item_t;

  // Configuration register indexes
  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_CENTER_Z   = 3'd2;
  localparam logic [2:0] REG_HALF_WIDTH = 3'd3;
  localparam logic [2:0] REG_LEVELS     = 3'd4;

  // Stop causes
  localparam logic [1:0] CAUSE_OUTSIDE  = 2'd0;
  localparam logic [1:0] CAUSE_STRADDLE = 2'd1;
  localparam logic [1:0] CAUSE_DEEPEST  = 2'd2;

  // Square/accumulate sequencer steps
  localparam logic [2:0] SQ_X     = 3'd0;
  localparam logic [2:0] SQ_Y     = 3'd1;
  localparam logic [2:0] SQ_Z     = 3'd2;
  localparam logic [2:0] SQ_LIM   = 3'd3;
  localparam logic [2:0] SQ_CMP   = 3'd4;

  // Path and depth limits fixed by the result fields
  localparam int PATH_SLOTS = 7;
  localparam int LEVEL_CAP  = 8;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       diff;
    logic       sq;
    logic [2:0] sq_cnt;
    logic       descend;
    logic       finish;
    logic [1:0] cause;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic far;
    logic straddle;
    logic beyond;
    logic last;
  } status_t;

endpackage

[rtl/oil_ctrl.sv]
// Controller: per-node sequencing of difference, squaring and decision steps.
module oil_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  oil_pkg::status_t  status,
  output oil_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= oil_pkg::SQ_X;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.sq_cnt  = cnt_r;
    cmd.cause   = oil_pkg::CAUSE_DEEPEST;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        cnt_nxt   = oil_pkg::SQ_X;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        if (cnt_r == oil_pkg::SQ_X && status.far) begin
          // some axis alone is past the bound: no squares needed
          cmd.finish = 1'b1;
          cmd.cause  = oil_pkg::CAUSE_OUTSIDE;
          state_nxt  = ST_IDLE;
        end else if (cnt_r == oil_pkg::SQ_CMP) begin
          if (status.beyond) begin
            cmd.finish = 1'b1;
            cmd.cause  = oil_pkg::CAUSE_OUTSIDE;
            state_nxt  = ST_IDLE;
          end else if (status.straddle) begin
            cmd.finish = 1'b1;
            cmd.cause  = oil_pkg::CAUSE_STRADDLE;
            state_nxt  = ST_IDLE;
          end else if (status.last) begin
            cmd.finish = 1'b1;
            cmd.cause  = oil_pkg::CAUSE_DEEPEST;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.descend = 1'b1;
            state_nxt   = ST_DIFF;
          end
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/oil_dp.sv]
// Datapath: config registers, node center tracking, shared squarer, result register.
module oil_dp #(
  parameter int MAX_LEVELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  oil_pkg::in_item_t  in_item,
  input  oil_pkg::cmd_t      cmd,
  output oil_pkg::status_t   status,
  output logic               out_valid,
  output oil_pkg::out_item_t out_item
);

  localparam int LEV_LIM = (MAX_LEVELS < oil_pkg::LEVEL_CAP) ? MAX_LEVELS : oil_pkg::LEVEL_CAP;
  localparam logic [3:0] LEV_MAX = 4'(LEV_LIM);

  // Configuration registers
  logic [31:0] cfg_cx_r, cfg_cy_r, cfg_cz_r;
  logic [29:0] cfg_hw_r;
  logic [3:0]  cfg_lev_r;

  // Per-item working registers
  logic [31:0] px_r, py_r, pz_r;
  logic [29:0] rad_r;
  logic [32:0] cx_r, cy_r, cz_r;
  logic [29:0] hw_r;
  logic [20:0] path_r;
  logic [2:0]  depth_r;

  // Node test registers
  logic [31:0] ax_r, ay_r, az_r;
  logic [31:0] lim_r;
  logic        far_r, straddle_r;
  logic [2:0]  idx_r;
  logic [63:0] prod_r;
  logic [65:0] acc_r;

  logic               out_valid_r;
  oil_pkg::out_item_t out_item_r;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cx_r  <= '0;
      cfg_cy_r  <= '0;
      cfg_cz_r  <= '0;
      cfg_hw_r  <= 30'd4194304;
      cfg_lev_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_idx)
        oil_pkg::REG_CENTER_X:   cfg_cx_r  <= cfg_wdata;
        oil_pkg::REG_CENTER_Y:   cfg_cy_r  <= cfg_wdata;
        oil_pkg::REG_CENTER_Z:   cfg_cz_r  <= cfg_wdata;
        oil_pkg::REG_HALF_WIDTH: cfg_hw_r  <= cfg_wdata[29:0];
        oil_pkg::REG_LEVELS:     cfg_lev_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Effective level count: zero acts as one, capped at the limit
  logic [3:0] lev_eff;
  always_comb begin
    if (cfg_lev_r == 4'd0)         lev_eff = 4'd1;
    else if (cfg_lev_r > LEV_MAX)  lev_eff = LEV_MAX;
    else                           lev_eff = cfg_lev_r;
  end

  // Offsets from the node center and their magnitudes
  logic [33:0] dx, dy, dz;
  logic [33:0] mx, my, mz;
  logic [31:0] lim_w;
  assign dx = {{2{px_r[31]}}, px_r} - {cx_r[32], cx_r};
  assign dy = {{2{py_r[31]}}, py_r} - {cy_r[32], cy_r};
  assign dz = {{2{pz_r[31]}}, pz_r} - {cz_r[32], cz_r};
  assign mx = dx[33] ? (~dx + 34'd1) : dx;
  assign my = dy[33] ? (~dy + 34'd1) : dy;
  assign mz = dz[33] ? (~dz + 34'd1) : dz;
  assign lim_w = {2'b0, rad_r} + {1'b0, hw_r, 1'b0};

  // Shared squarer operand select
  logic [31:0] op_w;
  logic [63:0] prod_w;
  always_comb begin
    case (cmd.sq_cnt)
      oil_pkg::SQ_X:   op_w = ax_r;
      oil_pkg::SQ_Y:   op_w = ay_r;
      oil_pkg::SQ_Z:   op_w = az_r;
      oil_pkg::SQ_LIM: op_w = lim_r;
      default:         op_w = lim_r;
    endcase
  end
  assign prod_w = op_w * op_w;

  // Child center step
  logic [32:0] step_w;
  assign step_w = {4'b0, hw_r[29:1]};

  always_ff @(posedge clk) begin
    // item load
    if (cmd.load) begin
      px_r    <= in_item.pos_x;
      py_r    <= in_item.pos_y;
      pz_r    <= in_item.pos_z;
      rad_r   <= in_item.bound_radius;
      cx_r    <= {cfg_cx_r[31], cfg_cx_r};
      cy_r    <= {cfg_cy_r[31], cfg_cy_r};
      cz_r    <= {cfg_cz_r[31], cfg_cz_r};
      hw_r    <= cfg_hw_r;
      path_r  <= '0;
      depth_r <= '0;
    end
    // per-node axis tests; squares are only used when no axis is past the bound
    if (cmd.diff) begin
      ax_r       <= mx[31:0];
      ay_r       <= my[31:0];
      az_r       <= mz[31:0];
      lim_r      <= lim_w;
      far_r      <= (mx > {2'b0, lim_w}) || (my > {2'b0, lim_w}) ||
                    (mz > {2'b0, lim_w});
      straddle_r <= (mx <= {4'b0, rad_r}) || (my <= {4'b0, rad_r}) ||
                    (mz <= {4'b0, rad_r});
      idx_r      <= {!dz[33] && (dz != '0), !dy[33] && (dy != '0), !dx[33] && (dx != '0)};
    end
    // square and accumulate
    if (cmd.sq) begin
      if (cmd.sq_cnt <= oil_pkg::SQ_LIM) prod_r <= prod_w;
      if (cmd.sq_cnt == oil_pkg::SQ_Y) acc_r <= {2'b0, prod_r};
      else if (cmd.sq_cnt == oil_pkg::SQ_Z || cmd.sq_cnt == oil_pkg::SQ_LIM)
        acc_r <= acc_r + {2'b0, prod_r};
    end
    // descend into the chosen octant
    if (cmd.descend) begin
      cx_r    <= idx_r[0] ? (cx_r + step_w) : (cx_r - step_w);
      cy_r    <= idx_r[1] ? (cy_r + step_w) : (cy_r - step_w);
      cz_r    <= idx_r[2] ? (cz_r + step_w) : (cz_r - step_w);
      hw_r    <= {1'b0, hw_r[29:1]};
      depth_r <= depth_r + 3'd1;
      for (int i = 0; i < oil_pkg::PATH_SLOTS; i++) begin
        if (depth_r == 3'(i)) path_r[3*i +: 3] <= idx_r;
      end
    end
    // result capture
    if (cmd.finish) begin
      out_item_r.node_path  <= path_r;
      out_item_r.descents   <= depth_r;
      out_item_r.stop_cause <= cmd.cause;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.finish;
  end

  assign status.far      = far_r;
  assign status.straddle = straddle_r;
  assign status.beyond   = acc_r > {2'b0, prod_r};
  assign status.last     = ({1'b0, depth_r} + 4'd1) >= lev_eff;
  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;

endmodule

[rtl/octree_insert_locator.sv]
// Top level: finds the implicit octree node that holds an object's bounding sphere.
// Per node visited: a difference step, four square steps and a compare step; a node is
// left right after its difference step when one axis alone lies past its bound.
// Throughput: one item at a time; busy stays high until the strobe, and the single
// shared squarer is used for all four squares of each node.
// Reset: rst_n low clears the controller and the strobe and restores register defaults.
module octree_insert_locator #(
  parameter int MAX_LEVELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  oil_pkg::in_item_t  in_item,
  output logic               out_valid,
  output oil_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata
);

  oil_pkg::cmd_t    cmd;
  oil_pkg::status_t status;

  // Sequencer
  oil_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Arithmetic and storage
  oil_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
